>>> src/baae_pkg.sv
// shared types and codes for the byte array edit engine
// no dependencies; used by baae_cell and byte_array_edit_engine
package baae_pkg;

	localparam int BYTE_W  = 8;
	localparam int OP_W    = 3;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;
	localparam int DEPTH_DEFAULT = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd1;
	localparam logic [OP_W-1:0] OP_POP     = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_CAP   = 2'd2;

	// what every cell does this cycle
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MIRROR = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FAR    = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] item;
	} cell_ctl_t;

endpackage

>>> src/baae_cell.sv
// one storage cell of the byte row: holds a byte, loads from its neighbours,
// its mirror cell, a far cell or the incoming byte; depends on baae_pkg
module baae_cell
	import baae_pkg::*;
#(
	parameter int POS = 0,
	parameter int AW  = 4
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [AW-1:0]     pos,
	input  logic [BYTE_W-1:0] left,
	input  logic [BYTE_W-1:0] right,
	input  logic [BYTE_W-1:0] mirror,
	input  logic [BYTE_W-1:0] far,
	output logic [BYTE_W-1:0] data_q
);

	localparam logic [AW-1:0] MY_POS = AW'(POS);

	logic [BYTE_W-1:0] data_n;

	always_comb begin
		data_n = data_q;
		case (ctl.mode)
			MODE_WRITE: begin
				if (MY_POS == pos) data_n = ctl.item;
			end
			MODE_INSERT: begin
				// later bytes move up one place
				if (MY_POS > pos) data_n = left;
				else if (MY_POS == pos) data_n = ctl.item;
			end
			MODE_DELETE: begin
				if (MY_POS >= pos) data_n = right;
			end
			MODE_MIRROR: data_n = mirror;
			MODE_FAR:    data_n = far;
			default:     data_n = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

endmodule

>>> src/byte_array_edit_engine.sv
// Byte array edit engine: an ordered row of up to DEPTH bytes plus a length, edited by
// lookup, push, pop, insert, delete and reverse. Every operation but reverse finishes in
// the cycle it is taken, so the block takes one word per cycle while the output register
// is free or being read. Reverse of two to DEPTH-1 bytes first mirrors the whole row of
// cells, then for each bit of (DEPTH - length), lowest first, moves the row down by that
// power of two where that bit is set; no new word is taken meanwhile, though its
// result is offered at once. Reverse of 0, 1 or DEPTH bytes needs no shift steps. A failed
// operation leaves the row unchanged and returns a nonzero status.
// depends on baae_pkg and baae_cell
module byte_array_edit_engine
	import baae_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    op,
	input  logic [INDEX_W-1:0] index,
	input  logic [BYTE_W-1:0]  item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  value,
	output logic [COUNT_W-1:0] count,
	output logic [STAT_W-1:0]  status
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_SHIFT = 1'b1;

	logic              state_q;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     shamt_q;
	logic [AW-1:0]     step_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;
	logic [STAT_W-1:0] status_q;

	logic [BYTE_W-1:0] cell_q [DEPTH];
	logic [BYTE_W-1:0] cand [DEPTH][AW];
	logic [BYTE_W-1:0] far [DEPTH];

	cell_ctl_t         ctl;
	logic [AW-1:0]     pos;
	logic [AW-1:0]     rd_addr;
	logic              accept;
	logic              empty;
	logic              full;
	logic [CW-1:0]     idx_x;
	logic [CW-1:0]     len_x;
	logic [STAT_W-1:0] status_n;
	logic [BYTE_W-1:0] value_n;
	logic [LW-1:0]     len_n;
	logic              start_shift;
	logic [LW-1:0]     gap;

	assign in_stall  = (state_q == S_SHIFT) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign count     = count_q;
	assign status    = status_q;

	assign empty = (len_q == '0);
	assign full  = (len_q == LW'(DEPTH));
	assign idx_x = CW'(index);
	assign len_x = CW'(len_q);
	assign gap   = LW'(DEPTH) - len_q;

	// operation decode and checks
	always_comb begin
		status_n    = ST_OK;
		len_n       = len_q;
		rd_addr     = AW'(idx_x);
		pos         = AW'(idx_x);
		ctl.mode    = MODE_HOLD;
		ctl.item    = item;
		start_shift = 1'b0;
		case (op)
			OP_LOOKUP: begin
				if (empty) status_n = ST_CAP;
				else if (idx_x >= len_x) status_n = ST_RANGE;
			end
			OP_PUSH: begin
				pos = AW'(len_q);
				if (full) status_n = ST_CAP;
				else begin
					ctl.mode = MODE_WRITE;
					len_n    = len_q + 1'b1;
				end
			end
			OP_POP: begin
				rd_addr = AW'(len_q - 1'b1);
				if (empty) status_n = ST_CAP;
				else len_n = len_q - 1'b1;
			end
			OP_INSERT: begin
				if (full) status_n = ST_CAP;
				else if (idx_x > len_x) status_n = ST_RANGE;
				else begin
					ctl.mode = MODE_INSERT;
					len_n    = len_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (empty) status_n = ST_CAP;
				else if (idx_x >= len_x) status_n = ST_RANGE;
				else begin
					ctl.mode = MODE_DELETE;
					len_n    = len_q - 1'b1;
				end
			end
			OP_REVERSE: begin
				// mirror the full row, then slide the used bytes down to cell zero
				if (len_q > LW'(1)) ctl.mode = MODE_MIRROR;
				start_shift = (len_q > LW'(1)) && !full;
			end
			default: ;
		endcase
		if (!accept) begin
			ctl.mode    = MODE_HOLD;
			start_shift = 1'b0;
		end
		if (state_q == S_SHIFT) begin
			ctl.mode = ((step_q & shamt_q) != '0) ? MODE_FAR : MODE_HOLD;
		end
	end

	always_comb begin
		value_n = '0;
		if (status_n == ST_OK && (op == OP_LOOKUP || op == OP_POP)) value_n = cell_q[rd_addr];
	end

	// far source: cell i+2^k, or itself past the end of the row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cand
		for (genvar k = 0; k < AW; k++) begin : g_step
			if (i + (1 << k) < DEPTH) begin : g_in
				assign cand[i][k] = cell_q[i + (1 << k)];
			end else begin : g_out
				assign cand[i][k] = cell_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			far[i] = '0;
			for (int k = 0; k < AW; k++) begin
				if (step_q[k]) far[i] = far[i] | cand[i][k];
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		baae_cell #(
			.POS(i),
			.AW (AW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (pos),
			.left  (cell_q[(i > 0) ? i - 1 : i]),
			.right (cell_q[(i < DEPTH - 1) ? i + 1 : i]),
			.mirror(cell_q[DEPTH - 1 - i]),
			.far   (far[i]),
			.data_q(cell_q[i])
		);
	end

	// control: length, shift sequencer, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			step_q      <= '0;
			shamt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (status_n == ST_OK) len_q <= len_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start_shift) begin
						state_q <= S_SHIFT;
						shamt_q <= gap[AW-1:0];
						step_q  <= AW'(1);
					end
				end
				S_SHIFT: begin
					step_q <= step_q << 1;
					if (step_q[AW-1]) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= value_n;
			count_q  <= COUNT_W'((status_n == ST_OK) ? len_n : len_q);
			status_q <= status_n;
		end
	end

endmodule
